/* rtl/pcpa_pkg.sv */
// Shared constants, codes and adder request/response types of the per-CPU page allocator.
package pcpa_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int NUM_CPUS_DEF   = 8;
    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_BYTES_DEF = 4096;

    // Fixed field widths
    localparam int ADDR_W  = 32;
    localparam int CPU_W   = 3;
    localparam int IDX_W   = 16;
    localparam int STAT_W  = 2;
    localparam int LIMIT_W = 7;
    localparam int APB_AW  = 4;
    localparam int ALU_W   = 33;

    // Empty-list marker for heads and links
    localparam logic [IDX_W-1:0] NULL_IDX = '1;

    // Register reset values
    localparam logic [ADDR_W-1:0]  REGION_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0]  REGION_END_RST   = 32'h8800_0000;
    localparam logic [LIMIT_W-1:0] STEAL_RST        = 7'd64;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END   = 2'd1;
    localparam logic [1:0] REG_STEAL = 2'd2;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD = 2'd2;

    // Request to the shared adder/subtractor
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] op_a;
        logic [ALU_W-1:0] op_b;
    } alu_req_t;

    // Response of the shared adder/subtractor
    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             no_borrow;
    } alu_rsp_t;

endpackage

/* rtl/pcpa_alu.sv */
// Shared 33-bit adder/subtractor used for range checks, index and address arithmetic.
module pcpa_alu (
    input  pcpa_pkg::alu_req_t req,
    output pcpa_pkg::alu_rsp_t rsp
);

    logic [pcpa_pkg::ALU_W:0] ext;

    // Add or subtract with one extra bit for the carry/borrow
    always_comb begin
        if (req.sub) begin
            ext = {1'b0, req.op_a} - {1'b0, req.op_b};
        end else begin
            ext = {1'b0, req.op_a} + {1'b0, req.op_b};
        end
        rsp.sum       = ext[pcpa_pkg::ALU_W-1:0];
        rsp.no_borrow = !ext[pcpa_pkg::ALU_W];
    end

endmodule

/* rtl/per_cpu_page_allocator_with_steal_top.sv */
// Per-CPU page allocator with page stealing: top level, sequencer, list heads and link memory.
//
// Each CPU owns a last-in-first-out free list of pages; links live in a single-port-read
// link memory of NUM_PAGES entries (no clearing pass: a link is only read after a free
// wrote it). One request is worked at a time; s_ready is high only while the sequencer is
// idle, and a finished result waits in the output register so the next request can start.
// A free steps through ST_BASE, ST_FCHK1, ST_FCHK2, ST_FIDX and ST_DONE. An allocate from a
// non-empty list steps through ST_BASE, ST_ACHK, ST_PRD, ST_PWB and ST_DONE; from an empty
// list it first scans the other CPUs in ST_SCAN, moving at most steal_limit pages in ST_SMOV.
// The steps are set by the registered read of the link memory (each pop is a read then a
// write) and by the one shared adder that does the region checks, the page index and the granted address in turn.
module per_cpu_page_allocator_with_steal_top #(
    parameter int NUM_CPUS   = pcpa_pkg::NUM_CPUS_DEF,
    parameter int NUM_PAGES  = pcpa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = pcpa_pkg::PAGE_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [pcpa_pkg::CPU_W-1:0]    s_cpu,
    input  logic [pcpa_pkg::ADDR_W-1:0]   s_page_address,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pcpa_pkg::ADDR_W-1:0]   m_granted_address,
    output logic [pcpa_pkg::STAT_W-1:0]   m_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcpa_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int PG_SHIFT = $clog2(PAGE_BYTES);
    localparam int MEM_AW   = $clog2(NUM_PAGES);
    localparam int CPU_IW   = $clog2(NUM_CPUS);
    localparam int VI_W     = $clog2(NUM_CPUS + 1);
    localparam int ALU_W    = pcpa_pkg::ALU_W;
    localparam int IDX_W    = pcpa_pkg::IDX_W;
    localparam int ADDR_W   = pcpa_pkg::ADDR_W;
    localparam int LIMIT_W  = pcpa_pkg::LIMIT_W;
    localparam int STAT_W   = pcpa_pkg::STAT_W;
    localparam logic [ALU_W-1:0] PG_MASK = ALU_W'(PAGE_BYTES - 1);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_BASE  = 11'b000_0000_0010,
        ST_FCHK1 = 11'b000_0000_0100,
        ST_FCHK2 = 11'b000_0000_1000,
        ST_FIDX  = 11'b000_0001_0000,
        ST_ACHK  = 11'b000_0010_0000,
        ST_SCAN  = 11'b000_0100_0000,
        ST_SMOV  = 11'b000_1000_0000,
        ST_PRD   = 11'b001_0000_0000,
        ST_PWB   = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic                       cmd_reg, cmd_next;
    logic [pcpa_pkg::CPU_W-1:0] cpu_reg, cpu_next;
    logic [ADDR_W-1:0]          pa_reg, pa_next;
    logic [ALU_W-1:0]           base_reg, base_next;
    logic                       ok_reg, ok_next;
    logic [IDX_W-1:0]           own_reg, own_next;
    logic [IDX_W-1:0]           s_reg, s_next;
    logic [LIMIT_W-1:0]         left_reg, left_next;
    logic [VI_W-1:0]            vi_reg, vi_next;
    logic [ADDR_W-1:0]          res_addr_reg, res_addr_next;
    logic [STAT_W-1:0]          res_stat_reg, res_stat_next;
    logic                       m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]          m_addr_reg, m_addr_next;
    logic [STAT_W-1:0]          m_stat_reg, m_stat_next;

    logic [ADDR_W-1:0]          region_start_reg;
    logic [ADDR_W-1:0]          region_end_reg;
    logic [LIMIT_W-1:0]         steal_limit_reg;

    // list heads: one read port, one write port
    logic [IDX_W-1:0]           head_reg [NUM_CPUS];
    logic [CPU_IW-1:0]          head_raddr;
    logic [IDX_W-1:0]           head_rd;
    logic                       head_we;
    logic [CPU_IW-1:0]          head_waddr;
    logic [IDX_W-1:0]           head_wdata;

    // link memory
    logic [IDX_W-1:0]           next_mem [NUM_PAGES];
    logic [IDX_W-1:0]           mem_rdata_reg;
    logic [MEM_AW-1:0]          mem_raddr;
    logic                       mem_we;
    logic [MEM_AW-1:0]          mem_waddr;
    logic [IDX_W-1:0]           mem_wdata;

    pcpa_pkg::alu_req_t         alu_req;
    pcpa_pkg::alu_rsp_t         alu_rsp;

    logic [CPU_IW-1:0]          cpu_idx;
    logic [CPU_IW-1:0]          vi_idx;
    logic                       cpu_ok;
    logic [ALU_W-1:0]           idx_full;
    logic                       idx_fits;
    logic [IDX_W-1:0]           idx_new;
    logic                       cfg_wr;

    pcpa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign cpu_idx  = CPU_IW'(cpu_reg);
    assign vi_idx   = vi_reg[CPU_IW-1:0];
    assign cpu_ok   = 32'(cpu_reg) < NUM_CPUS;
    assign idx_full = alu_rsp.sum >> PG_SHIFT;
    assign idx_fits = idx_full < ALU_W'(NUM_PAGES);
    assign idx_new  = idx_full[IDX_W-1:0];

    // Select the head read address: scanned CPU while stealing, else the requester
    assign head_raddr = (state_reg == ST_SCAN) ? vi_idx : cpu_idx;
    assign head_rd    = head_reg[head_raddr];
    assign mem_raddr  = (state_reg == ST_SCAN) ? MEM_AW'(head_rd) : MEM_AW'(own_reg);

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_addr_reg;
    assign m_status          = m_stat_reg;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            pcpa_pkg::REG_START: prdata = region_start_reg;
            pcpa_pkg::REG_END:   prdata = region_end_reg;
            pcpa_pkg::REG_STEAL: prdata = 32'(steal_limit_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_start_reg <= pcpa_pkg::REGION_START_RST;
            region_end_reg   <= pcpa_pkg::REGION_END_RST;
            steal_limit_reg  <= pcpa_pkg::STEAL_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pcpa_pkg::REG_START: region_start_reg <= pwdata;
                pcpa_pkg::REG_END:   region_end_reg   <= pwdata;
                pcpa_pkg::REG_STEAL: steal_limit_reg  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Link memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            next_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= next_mem[mem_raddr];
    end

    // List heads: all empty after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CPUS; i++) begin
                head_reg[i] <= pcpa_pkg::NULL_IDX;
            end
        end else if (head_we) begin
            head_reg[head_waddr] <= head_wdata;
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cpu_next      = cpu_reg;
        pa_next       = pa_reg;
        base_next     = base_reg;
        ok_next       = ok_reg;
        own_next      = own_reg;
        s_next        = s_reg;
        left_next     = left_reg;
        vi_next       = vi_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_stat_next   = m_stat_reg;
        head_we       = 1'b0;
        head_waddr    = cpu_idx;
        head_wdata    = own_reg;
        mem_we        = 1'b0;
        mem_waddr     = MEM_AW'(s_reg);
        mem_wdata     = own_reg;
        alu_req       = '{sub: 1'b0, op_a: '0, op_b: '0};

        // drop the result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_command;
                    cpu_next   = s_cpu;
                    pa_next    = s_page_address;
                    state_next = ST_BASE;
                end
            end
            // base = region_start rounded up to a page
            ST_BASE: begin
                alu_req       = '{sub: 1'b0, op_a: ALU_W'(region_start_reg), op_b: PG_MASK};
                base_next     = alu_rsp.sum & ~PG_MASK;
                res_addr_next = '0;
                state_next    = (cmd_reg == pcpa_pkg::CMD_FREE) ? ST_FCHK1 : ST_ACHK;
            end
            // free: aligned, cpu in range and address at or above region_start
            ST_FCHK1: begin
                alu_req    = '{sub: 1'b1, op_a: ALU_W'(pa_reg), op_b: ALU_W'(region_start_reg)};
                ok_next    = cpu_ok && (pa_reg[PG_SHIFT-1:0] == '0) && alu_rsp.no_borrow;
                state_next = ST_FCHK2;
            end
            // free: address below region_end
            ST_FCHK2: begin
                alu_req    = '{sub: 1'b1, op_a: ALU_W'(pa_reg), op_b: ALU_W'(region_end_reg)};
                ok_next    = ok_reg && !alu_rsp.no_borrow;
                state_next = ST_FIDX;
            end
            // free: page index, then push onto the requester's list
            ST_FIDX: begin
                alu_req = '{sub: 1'b1, op_a: ALU_W'(pa_reg), op_b: base_reg};
                if (ok_reg && alu_rsp.no_borrow && idx_fits) begin
                    mem_we        = 1'b1;
                    mem_waddr     = MEM_AW'(idx_new);
                    mem_wdata     = head_rd;
                    head_we       = 1'b1;
                    head_waddr    = cpu_idx;
                    head_wdata    = idx_new;
                    res_stat_next = pcpa_pkg::STAT_OK;
                end else begin
                    res_stat_next = pcpa_pkg::STAT_BAD;
                end
                state_next = ST_DONE;
            end
            // allocate: fail on a bad cpu, else load own head, start stealing if empty
            ST_ACHK: begin
                if (!cpu_ok) begin
                    res_stat_next = pcpa_pkg::STAT_OOM;
                    state_next    = ST_DONE;
                end else begin
                    own_next = head_rd;
                    if (head_rd != pcpa_pkg::NULL_IDX) begin
                        state_next = ST_PRD;
                    end else begin
                        left_next  = steal_limit_reg;
                        vi_next    = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            // steal: visit other CPUs in ascending order
            ST_SCAN: begin
                if (left_reg == '0 || vi_reg == VI_W'(NUM_CPUS)) begin
                    state_next = ST_PRD;
                end else if (vi_idx == cpu_idx || head_rd == pcpa_pkg::NULL_IDX) begin
                    vi_next = vi_reg + VI_W'(1);
                end else if (32'(head_rd) >= NUM_PAGES) begin
                    head_we    = 1'b1;
                    head_waddr = vi_idx;
                    head_wdata = pcpa_pkg::NULL_IDX;
                    vi_next    = vi_reg + VI_W'(1);
                end else begin
                    s_next     = head_rd;
                    state_next = ST_SMOV;
                end
            end
            // steal: move one page onto the own list
            ST_SMOV: begin
                head_we    = 1'b1;
                head_waddr = vi_idx;
                head_wdata = mem_rdata_reg;
                mem_we     = 1'b1;
                mem_waddr  = MEM_AW'(s_reg);
                mem_wdata  = own_reg;
                own_next   = s_reg;
                left_next  = left_reg - LIMIT_W'(1);
                state_next = ST_SCAN;
            end
            // pop: fail on an empty or out-of-range head, else read the link
            ST_PRD: begin
                if (own_reg == pcpa_pkg::NULL_IDX || 32'(own_reg) >= NUM_PAGES) begin
                    head_we       = 1'b1;
                    head_waddr    = cpu_idx;
                    head_wdata    = own_reg;
                    res_stat_next = pcpa_pkg::STAT_OOM;
                    state_next    = ST_DONE;
                end else begin
                    state_next = ST_PWB;
                end
            end
            // pop: advance the head and form the granted address
            ST_PWB: begin
                alu_req       = '{sub: 1'b0, op_a: base_reg,
                                  op_b: ALU_W'(own_reg) << PG_SHIFT};
                res_addr_next = alu_rsp.sum[ADDR_W-1:0];
                res_stat_next = pcpa_pkg::STAT_OK;
                head_we       = 1'b1;
                head_waddr    = cpu_idx;
                head_wdata    = mem_rdata_reg;
                state_next    = ST_DONE;
            end
            // hold until the output register is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        cpu_reg      <= cpu_next;
        pa_reg       <= pa_next;
        base_reg     <= base_next;
        ok_reg       <= ok_next;
        own_reg      <= own_next;
        s_reg        <= s_next;
        left_reg     <= left_next;
        vi_reg       <= vi_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        m_addr_reg   <= m_addr_next;
        m_stat_reg   <= m_stat_next;
    end

    // A transfer always starts with the base computation
    a_accept_to_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_BASE))
        else $error("accepted request did not start the sequencer");

    // A page move needs budget left and never targets the requester itself
    a_steal_budget: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SMOV) |-> (left_reg != '0 && vi_idx != cpu_idx))
        else $error("steal move without budget or from own list");

    // A moved page index lies inside the link memory
    a_move_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SMOV) |-> (32'(s_reg) < NUM_PAGES))
        else $error("stolen page index outside the link memory");

    // Failed results carry a zero address
    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg != pcpa_pkg::STAT_OK) |-> (m_addr_reg == '0))
        else $error("failed result with nonzero address");

endmodule
